// File: rtl/asq_pkg.sv
// Shared types and constants for the arpeggiator step sequencer.
// Depends on nothing; the top level and the checker import it.
`default_nettype none

package asq_pkg;

  localparam int PITCH_W     = 16;
  localparam int PITCH_OUT_W = 15;
  localparam int CHAN_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int SEL_W       = 4;
  localparam int INDEX_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int OFFSET_W    = 4;

  // Output pitch is clamped to +/-10 V, in millivolts.
  localparam logic signed [PITCH_W-1:0] PITCH_HI = 16'sd10000;
  localparam logic signed [PITCH_W-1:0] PITCH_LO = -16'sd10000;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_COUNT  = 2'd1,
    ACT_CLOCK  = 2'd2,
    ACT_UNPLUG = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PAT_RIGHT      = 2'd0,
    PAT_LEFT       = 2'd1,
    PAT_RIGHT_LEFT = 2'd2,
    PAT_LEFT_RIGHT = 2'd3
  } pattern_t;

  localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLAY_LAST_NOTE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_USE_GATES      = 2'd2;

endpackage

`default_nettype wire

// File: rtl/arpeggiator_step_sequencer_unit.sv
// Top level of the arpeggiator step sequencer: control sequencer and state.
// Depends on asq_pkg, asq_ram (live and sequence stores) and asq_mod.
//
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// command   | start / busy       | action, channel, pitch_mv, gate_high,
//           |                    | channel_count, pattern_select
// result    | done (one cycle)   | pitch_out_mv, note_strobe, note_index,
//           |                    | end_of_cycle, running
// config    | cfg_we             | cfg_index, cfg_data
//
// A beat is taken at an edge with start high and busy low. Channel writes, count
// writes and unplug beats finish in that edge: done rises in the following cycle
// and busy never rises. A clock beat that plays a note inside a cycle goes
// through the play, read and write states; the bouncing patterns first wait for
// the iterative remainder unit to reduce the bounced note index. A restart runs
// a compaction pass over the live store, a fix-up step and the start-offset
// remainder before its result beat. When a played note ends the cycle, the
// restart follows its play, read and write states and that note's result comes
// at the end of the restart. Reset is synchronous and active high; both stores
// hold no reset value and need no clearing pass. The receiver cannot stall:
// each result is shown once.
`default_nettype none

module arpeggiator_step_sequencer_unit #(
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_OFFSET   = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // command beats
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire asq_pkg::action_t                      action,
  input  wire logic        [asq_pkg::CHAN_W-1:0]     channel,
  input  wire logic signed [asq_pkg::PITCH_W-1:0]    pitch_mv,
  input  wire logic                                  gate_high,
  input  wire logic        [asq_pkg::COUNT_W-1:0]    channel_count,
  input  wire logic        [asq_pkg::SEL_W-1:0]      pattern_select,
  // result beats
  output logic                                       done,
  output logic signed      [asq_pkg::PITCH_OUT_W-1:0] pitch_out_mv,
  output logic                                       note_strobe,
  output logic             [asq_pkg::INDEX_W-1:0]    note_index,
  output logic                                       end_of_cycle,
  output logic                                       running,
  // configuration writes
  input  wire logic                                  cfg_we,
  input  wire logic        [asq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [asq_pkg::CFG_DATA_W-1:0] cfg_data
);

  import asq_pkg::*;

  // Store address width, length width (holds the depth itself) and the width
  // of a pattern position, which covers the longest bouncing cycle.
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LEN_W = $clog2(MAX_CHANNELS + 1);
  localparam int PW    = $clog2(2 * MAX_CHANNELS + MAX_OFFSET + 1);
  localparam int SW    = PW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAY,
    S_MODP,
    S_RD,
    S_WR,
    S_COMPACT,
    S_FIXUP,
    S_MODR
  } state_t;

  state_t state;

  // Configuration registers.
  logic [OFFSET_W-1:0] start_offset;
  logic                play_last_note;
  logic                use_gates;

  // Block state.
  logic [MAX_CHANNELS-1:0]  live_gate;
  logic [LEN_W-1:0]         live_count;
  logic [LEN_W-1:0]         seq_length;
  pattern_t                 active_pattern;
  logic [PW-1:0]            position;
  logic [PW-1:0]            end_position;
  logic                     is_running;
  logic                     eoc_pending;
  logic signed [PITCH_OUT_W-1:0] held_pitch;

  // Working registers of one beat.
  pattern_t         sel_q;
  logic             fin_q;
  logic [IDX_W-1:0] idx_q;
  logic [LEN_W-1:0] p;
  logic [LEN_W-1:0] n;
  logic             pend;
  logic             mod_start;
  logic [PW-1:0]    mod_a;
  logic [LEN_W-1:0] mod_b;
  logic             mod_done;
  logic [LEN_W-1:0] mod_rem;

  // Store ports.
  logic                    live_we;
  logic signed [PITCH_W-1:0] live_rdata;
  logic                    seq_we;
  logic [IDX_W-1:0]        seq_waddr;
  logic signed [PITCH_W-1:0] seq_wdata;
  logic signed [PITCH_W-1:0] seq_rdata;

  // Combinational helpers.
  logic                    accept;
  logic                    chan_ok;
  logic [LEN_W-1:0]        count_sat;
  pattern_t                sel_in;
  logic [PW-1:0]           off_sat;
  logic [LEN_W-1:0]        mag;
  logic signed [SW-1:0]    mag_s;
  logic signed [SW-1:0]    pos_s;
  logic signed [SW-1:0]    d1;
  logic signed [SW-1:0]    a1;
  logic signed [SW-1:0]    d2;
  logic signed [SW-1:0]    a2;
  logic [PW-1:0]           bounce_a;
  logic                    fin;
  logic [LEN_W-1:0]        n_fix;
  logic                    take;
  logic [PW-1:0]           e_base;
  logic [PW-1:0]           e_off;
  logic [PW-1:0]           e_end;
  logic signed [PITCH_OUT_W-1:0] clamped;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign pitch_out_mv = held_pitch;
  assign running      = is_running;

  always_comb begin
    chan_ok   = (32'(channel) < MAX_CHANNELS);
    count_sat = (32'(channel_count) > MAX_CHANNELS) ? LEN_W'(MAX_CHANNELS)
                                                    : LEN_W'(channel_count);
    sel_in    = (pattern_select <= SEL_W'(3)) ? pattern_t'(pattern_select[1:0])
                                              : PAT_RIGHT;
    off_sat   = (32'(start_offset) > MAX_OFFSET) ? PW'(MAX_OFFSET) : PW'(start_offset);
  end

  // Note index of the bouncing patterns, before the final remainder:
  // right-left folds the position twice about the top note, left-right once.
  always_comb begin
    mag      = seq_length - 1'b1;
    mag_s    = SW'(mag);
    pos_s    = SW'(position);
    d1       = mag_s - pos_s;
    a1       = (d1 < 0) ? -d1 : d1;
    d2       = mag_s - a1;
    a2       = (d2 < 0) ? -d2 : d2;
    bounce_a = (active_pattern == PAT_RIGHT_LEFT) ? PW'(a2) : PW'(a1);
  end

  always_comb begin
    unique case (active_pattern)
      PAT_RIGHT: fin = (position >= PW'(mag));
      PAT_LEFT:  fin = (position == '0);
      default:   fin = (position == end_position);
    endcase
  end

  // Restart bookkeeping: an empty selection becomes a single 0 mV note, and the
  // bouncing patterns get their end step from the length, offset and last-note flag.
  always_comb begin
    n_fix  = (n == '0) ? LEN_W'(1) : n;
    take   = !use_gates || live_gate[p[IDX_W-1:0]];
    e_base = (32'(n) < 2) ? PW'(1) : (PW'({n, 1'b0}) - PW'(3));
    if (e_base < off_sat) begin
      e_off = off_sat;
    end else if (off_sat != '0) begin
      e_off = e_base + 1'b1;
    end else begin
      e_off = e_base;
    end
    e_end = e_off + PW'(play_last_note);
  end

  always_comb begin
    if (seq_rdata > PITCH_HI) begin
      clamped = PITCH_OUT_W'(PITCH_HI);
    end else if (seq_rdata < PITCH_LO) begin
      clamped = PITCH_OUT_W'(PITCH_LO);
    end else begin
      clamped = PITCH_OUT_W'(seq_rdata);
    end
  end

  // Store write ports. The live store is written only between beats and the
  // sequence store only during a restart, so reads and writes never overlap.
  always_comb begin
    live_we   = accept && (action == ACT_WRITE) && chan_ok;
    seq_we    = ((state == S_COMPACT) && pend) || ((state == S_FIXUP) && (n == '0));
    seq_waddr = n[IDX_W-1:0];
    seq_wdata = (state == S_FIXUP) ? '0 : live_rdata;
  end

  asq_ram #(
    .DEPTH (MAX_CHANNELS),
    .WIDTH (PITCH_W),
    .AW    (IDX_W)
  ) u_live (
    .clk   (clk),
    .we    (live_we),
    .waddr (IDX_W'(channel)),
    .wdata (pitch_mv),
    .raddr (p[IDX_W-1:0]),
    .rdata (live_rdata)
  );

  asq_ram #(
    .DEPTH (MAX_CHANNELS),
    .WIDTH (PITCH_W),
    .AW    (IDX_W)
  ) u_seq (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .raddr (idx_q),
    .rdata (seq_rdata)
  );

  asq_mod #(
    .DW (PW),
    .BW (LEN_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_a),
    .divisor  (mod_b),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      note_strobe    <= 1'b0;
      note_index     <= '0;
      end_of_cycle   <= 1'b0;
      start_offset   <= '0;
      play_last_note <= 1'b0;
      use_gates      <= 1'b0;
      live_gate      <= '0;
      live_count     <= '0;
      seq_length     <= LEN_W'(1);
      active_pattern <= PAT_RIGHT;
      position       <= '0;
      end_position   <= '0;
      is_running     <= 1'b0;
      eoc_pending    <= 1'b0;
      held_pitch     <= '0;
      mod_start      <= 1'b0;
      pend           <= 1'b0;
    end else begin
      done      <= 1'b0;
      mod_start <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_OFFSET:   start_offset   <= cfg_data;
          REG_PLAY_LAST_NOTE: play_last_note <= cfg_data[0];
          REG_USE_GATES:      use_gates      <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            note_strobe  <= 1'b0;
            note_index   <= '0;
            end_of_cycle <= 1'b0;
            unique case (action)
              ACT_WRITE: begin
                if (chan_ok) begin
                  live_gate[IDX_W'(channel)] <= gate_high;
                end
                done <= 1'b1;
              end
              ACT_COUNT: begin
                live_count <= count_sat;
                done       <= 1'b1;
              end
              ACT_UNPLUG: begin
                is_running <= 1'b0;
                done       <= 1'b1;
              end
              ACT_CLOCK: begin
                end_of_cycle <= eoc_pending;
                eoc_pending  <= 1'b0;
                sel_q        <= sel_in;
                if (is_running) begin
                  state <= S_PLAY;
                end else begin
                  p     <= '0;
                  n     <= '0;
                  pend  <= 1'b0;
                  state <= S_COMPACT;
                end
              end
            endcase
          end
        end

        S_PLAY: begin
          fin_q <= fin;
          if ((active_pattern == PAT_RIGHT) || (active_pattern == PAT_LEFT)) begin
            idx_q <= IDX_W'(position);
            state <= S_RD;
          end else begin
            mod_start <= 1'b1;
            mod_a     <= bounce_a;
            mod_b     <= seq_length;
            state     <= S_MODP;
          end
        end

        S_MODP: begin
          if (mod_done) begin
            idx_q <= mod_rem[IDX_W-1:0];
            state <= S_RD;
          end
        end

        // The sequence store registers its read data during this cycle.
        S_RD: begin
          state <= S_WR;
        end

        S_WR: begin
          held_pitch  <= clamped;
          note_strobe <= 1'b1;
          note_index  <= INDEX_W'(idx_q);
          if (active_pattern == PAT_LEFT) begin
            position <= position - 1'b1;
          end else begin
            position <= position + 1'b1;
          end
          if (fin_q) begin
            eoc_pending <= 1'b1;
            p           <= '0;
            n           <= '0;
            pend        <= 1'b0;
            state       <= S_COMPACT;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        // One live channel is read per cycle; a selected one is appended to the
        // sequence store the cycle after, when its pitch comes out of the RAM.
        S_COMPACT: begin
          if (pend) begin
            n <= n + 1'b1;
          end
          if (p < live_count) begin
            pend <= take;
            p    <= p + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_FIXUP;
            end
          end
        end

        S_FIXUP: begin
          n         <= n_fix;
          mod_start <= 1'b1;
          mod_a     <= off_sat;
          mod_b     <= n_fix;
          state     <= S_MODR;
        end

        S_MODR: begin
          if (mod_done) begin
            seq_length     <= n;
            active_pattern <= sel_q;
            is_running     <= 1'b1;
            unique case (sel_q)
              PAT_RIGHT: begin
                position     <= PW'(mod_rem);
                end_position <= PW'(n - 1'b1);
              end
              PAT_LEFT: begin
                position     <= PW'(n - 1'b1 - mod_rem);
                end_position <= '0;
              end
              default: begin
                position     <= off_sat;
                end_position <= e_end;
              end
            endcase
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/asq_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the live chord store and the sequence store; no package needed.
`default_nettype none

module asq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered; an address past the depth reads unknown data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/asq_mod.sv
// Iterative remainder unit: one restoring shift-subtract step per cycle.
// Used for the start offset and the bounced note index; no package needed.
`default_nettype none

module asq_mod #(
  parameter int DW = 6,
  parameter int BW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [BW-1:0] divisor,
  output logic               done,
  output logic      [BW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          active;
  logic [CW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [BW-1:0] div;
  logic [BW:0]   trial;
  logic [BW:0]   rem_next;

  // The partial remainder stays below the divisor, so the trial fits BW+1 bits.
  always_comb begin
    trial    = {rem, quo[DW-1]};
    rem_next = (trial >= {1'b0, div}) ? (trial - {1'b0, div}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(DW);
        quo    <= dividend;
        div    <= divisor;
        rem    <= '0;
      end else if (active) begin
        rem <= rem_next[BW-1:0];
        quo <= quo << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/asq_checker.sv
// Port-level checks for the arpeggiator step sequencer, bound to the top level.
// Depends on asq_pkg and arpeggiator_step_sequencer_unit.
`default_nettype none

module asq_checker (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   start,
  input wire logic                                   busy,
  input wire asq_pkg::action_t                       action,
  input wire logic                                   done,
  input wire logic signed [asq_pkg::PITCH_OUT_W-1:0] pitch_out_mv,
  input wire logic                                   note_strobe,
  input wire logic                                   end_of_cycle,
  input wire logic                                   running
);

  import asq_pkg::*;

  // A result beat is only shown when the block is ready for the next command.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat shown while busy");

  // Channel write, count write and unplug commands complete in the cycle after they are taken.
  a_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action != ACT_CLOCK)) |=> (done && !busy))
    else $error("non-clock command did not complete in one cycle");

  // A result beat that shows a played note or an end of cycle comes with a pattern cycle running.
  a_clock_runs: assert property (@(posedge clk) disable iff (rst)
    (done && (note_strobe || end_of_cycle)) |-> running)
    else $error("played note or end of cycle without a running cycle");

  // The held pitch stays inside the clamp range at every result beat.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> ((pitch_out_mv <= 15'sd10000) && (pitch_out_mv >= -15'sd10000)))
    else $error("output pitch outside the clamp range");

endmodule

bind arpeggiator_step_sequencer_unit asq_checker u_asq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .done         (done),
  .pitch_out_mv (pitch_out_mv),
  .note_strobe  (note_strobe),
  .end_of_cycle (end_of_cycle),
  .running      (running)
);

`default_nettype wire
